[rtl/wfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared constants and types for the waveform frame statistics unit.
// ----------------------------------------------------------------------------
package wfs_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W = 17;
  localparam int unsigned SUM_W = 33;
  localparam int unsigned SQ_W = 47;
  localparam int unsigned RMS_W = 24;
  // Frame capacity; LEN_W is sized to hold it.
  localparam int unsigned MAX_SAMPLES = 65536;

  localparam logic [1:0] REG_WIN_START = 2'd0;
  localparam logic [1:0] REG_WIN_END = 2'd1;
  localparam logic [1:0] REG_STRIDE = 2'd2;
  localparam logic [1:0] REG_FEATURES = 2'd3;

  // Frame summary handed from the accumulator front to the math back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak;
    logic [SAMPLE_W-1:0] peak_pos;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0] sq_sum;
    logic [LEN_W-1:0] count;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] ustart;
    logic [LEN_W-1:0] uend;
    logic bad;
  } frame_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } math_state_t;

endpackage
`default_nettype wire

[rtl/wfs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_front
// Per-sample accumulators; builds one frame request at each due frame end.
// ----------------------------------------------------------------------------
module wfs_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic take,
  input wire logic signed [wfs_pkg::SAMPLE_W-1:0] sample,
  input wire logic sample_ok,
  input wire logic frame_end,
  input wire logic [15:0] window_start,
  input wire logic [16:0] window_end,
  input wire logic [7:0] frame_stride,
  input wire logic features_on,
  output logic req_valid,
  output wfs_pkg::frame_req_t req
);

  localparam logic signed [wfs_pkg::SAMPLE_W-1:0] SMAX = {1'b0, {(wfs_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [wfs_pkg::SAMPLE_W-1:0] SMIN = {1'b1, {(wfs_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic [wfs_pkg::LEN_W-1:0] MAX_LEN = wfs_pkg::LEN_W'(wfs_pkg::MAX_SAMPLES);

  logic [wfs_pkg::LEN_W-1:0] sample_index;
  logic [wfs_pkg::LEN_W-1:0] valid_count;
  logic signed [wfs_pkg::SUM_W-1:0] running_sum;
  logic [wfs_pkg::SQ_W-1:0] running_square_sum;
  logic signed [wfs_pkg::SAMPLE_W-1:0] running_min;
  logic signed [wfs_pkg::SAMPLE_W-1:0] running_max;
  logic signed [wfs_pkg::SAMPLE_W-1:0] best_peak;
  logic [wfs_pkg::SAMPLE_W-1:0] best_peak_pos;
  logic peak_found;
  logic [7:0] stride_phase;

  logic [wfs_pkg::SAMPLE_W-1:0] mag;
  logic [31:0] mag_sq;
  logic in_win, take_peak, last, due;
  logic [7:0] phase_inc;
  logic [wfs_pkg::LEN_W-1:0] len;
  logic [wfs_pkg::LEN_W-1:0] cnt_n;
  logic signed [wfs_pkg::SUM_W-1:0] sum_n;
  logic [wfs_pkg::SQ_W-1:0] sq_n;
  logic signed [wfs_pkg::SAMPLE_W-1:0] min_n, max_n, pk_n;
  logic [wfs_pkg::SAMPLE_W-1:0] pos_n;
  logic found_n;
  logic [wfs_pkg::LEN_W-1:0] us, ue;

  always_comb begin
    mag = sample[wfs_pkg::SAMPLE_W-1] ? wfs_pkg::SAMPLE_W'(-sample) : sample;
    mag_sq = mag * mag;
    len = sample_index + 1'b1;
    last = frame_end || (len >= MAX_LEN);
    in_win = (sample_index >= {1'b0, window_start}) &&
             ((window_end == '0) || (sample_index < window_end));
    take_peak = sample_ok && in_win && (!peak_found || sample > best_peak);
    cnt_n = valid_count + (sample_ok ? 17'd1 : 17'd0);
    sum_n = sample_ok ? running_sum + wfs_pkg::SUM_W'(sample) : running_sum;
    sq_n = sample_ok ? running_square_sum + wfs_pkg::SQ_W'(mag_sq) : running_square_sum;
    min_n = (sample_ok && sample < running_min) ? sample : running_min;
    max_n = (sample_ok && sample > running_max) ? sample : running_max;
    pk_n = take_peak ? sample : best_peak;
    pos_n = take_peak ? sample_index[wfs_pkg::SAMPLE_W-1:0] : best_peak_pos;
    found_n = peak_found || take_peak;
    phase_inc = stride_phase + 8'd1;
    due = (frame_stride <= 8'd1) || (phase_inc >= frame_stride);
    us = ({1'b0, window_start} < len) ? {1'b0, window_start} : len;
    ue = ((window_end == '0) || (window_end > len)) ? len : window_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      valid_count <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
      running_min <= SMAX;
      running_max <= SMIN;
      best_peak <= SMIN;
      best_peak_pos <= '0;
      peak_found <= 1'b0;
      stride_phase <= '0;
      req_valid <= 1'b0;
    end else begin
      req_valid <= 1'b0;
      if (take) begin
        if (!last) begin
          sample_index <= len;
          valid_count <= cnt_n;
          running_sum <= sum_n;
          running_square_sum <= sq_n;
          running_min <= min_n;
          running_max <= max_n;
          best_peak <= pk_n;
          best_peak_pos <= pos_n;
          peak_found <= found_n;
        end else begin
          stride_phase <= due ? 8'd0 : phase_inc;
          req_valid <= due && features_on;
          req.peak <= pk_n;
          req.peak_pos <= pos_n;
          req.min_v <= min_n;
          req.max_v <= max_n;
          req.sum <= sum_n;
          req.sq_sum <= sq_n;
          req.count <= cnt_n;
          req.len <= len;
          req.ustart <= us;
          req.uend <= ue;
          req.bad <= (cnt_n == '0) || (us >= ue) || !found_n;
          // clear frame
          sample_index <= '0;
          valid_count <= '0;
          running_sum <= '0;
          running_square_sum <= '0;
          running_min <= SMAX;
          running_max <= SMIN;
          best_peak <= SMIN;
          best_peak_pos <= '0;
          peak_found <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTH
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    sample_index < MAX_LEN) else $error("sample index overran");
  a_count_le_index: assert property (@(posedge clk) disable iff (rst)
    valid_count <= sample_index) else $error("valid count above index");
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    stride_phase != 8'hff) else $error("stride phase overran");
`endif

endmodule
`default_nettype wire

[rtl/wfs_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_queue
// Small request queue between the front and the math back end.
// ----------------------------------------------------------------------------
module wfs_queue #(
  parameter int unsigned DEPTH_LOG = 2
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic wr,
  input wire wfs_pkg::frame_req_t wdata,
  input wire logic rd,
  output logic has_data,
  output logic almost_full,
  output wfs_pkg::frame_req_t rdata
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG;

  wfs_pkg::frame_req_t mem [DEPTH];
  logic [DEPTH_LOG-1:0] wp, rp;
  logic [DEPTH_LOG:0] cnt;

  assign has_data = cnt != '0;
  assign almost_full = cnt >= (DEPTH_LOG+1)'(DEPTH - 1);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> cnt < (DEPTH_LOG+1)'(DEPTH) || rd) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> has_data) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (DEPTH_LOG+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[rtl/wfs_math.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_math
// Frame-end math: serial divides for mean and mean square, serial root,
// then a one-entry result register.
// ----------------------------------------------------------------------------
module wfs_math (
  input wire logic clk,
  input wire logic rst,
  input wire logic has_req,
  input wire wfs_pkg::frame_req_t req,
  output logic req_pop,
  output logic res_valid,
  input wire logic res_pop,
  output logic signed [15:0] peak_value,
  output logic [15:0] peak_pos,
  output logic signed [15:0] sample_min,
  output logic signed [15:0] sample_max,
  output logic signed [15:0] mean_value,
  output logic [15:0] rms_value,
  output logic [16:0] frame_length,
  output logic [16:0] used_start,
  output logic [16:0] used_end,
  output logic quality_bad
);

  localparam int unsigned SQ_W = wfs_pkg::SQ_W;
  localparam int unsigned SUM_W = wfs_pkg::SUM_W;
  localparam int unsigned LEN_W = wfs_pkg::LEN_W;
  localparam int unsigned CW = 6;

  wfs_pkg::math_state_t state, state_next;
  wfs_pkg::frame_req_t cur;
  logic [CW-1:0] step;
  // Both quotients share one shift loop: the square sum dividend is the widest.
  logic [SQ_W-1:0] q_sq;
  logic [LEN_W:0] r_sq;
  logic [SUM_W-1:0] q_m;
  logic [LEN_W:0] r_m;
  logic [SQ_W-1:0] rx;
  logic [31:0] rres;
  logic [31:0] rbit;
  logic neg;

  logic [LEN_W:0] r_sq_sh, r_m_sh;
  logic [33:0] trial;
  logic sq_bit, m_bit;
  logic [SUM_W-1:0] sum_mag;

  assign sum_mag = cur.sum[SUM_W-1] ? SUM_W'(-cur.sum) : SUM_W'(cur.sum);

  always_comb begin
    r_sq_sh = {r_sq[LEN_W-1:0], q_sq[SQ_W-1]};
    r_m_sh = {r_m[LEN_W-1:0], q_m[SUM_W-1]};
    sq_bit = r_sq_sh >= {1'b0, cur.count};
    m_bit = r_m_sh >= {1'b0, cur.count};
    trial = {2'b00, rres} + {2'b00, rbit};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wfs_pkg::ST_IDLE: if (has_req && !res_valid) state_next = wfs_pkg::ST_DIV;
      wfs_pkg::ST_DIV: if (step == CW'(SQ_W - 1)) state_next = wfs_pkg::ST_SQRT;
      wfs_pkg::ST_SQRT: if (rbit == '0) state_next = wfs_pkg::ST_DONE;
      wfs_pkg::ST_DONE: state_next = wfs_pkg::ST_IDLE;
      default: state_next = wfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_pop = (state == wfs_pkg::ST_IDLE) && has_req && !res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfs_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_pop) res_valid <= 1'b0;
      if (state == wfs_pkg::ST_DONE) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wfs_pkg::ST_IDLE: begin
        cur <= req;
        step <= '0;
        r_sq <= '0;
        r_m <= '0;
        q_sq <= req.sq_sum;
        q_m <= '0;
        neg <= req.sum[SUM_W-1];
      end
      wfs_pkg::ST_DIV: begin
        // hold the mean dividend so that its last of SUM_W shifts falls in the root seed step
        if (step <= CW'(SQ_W - SUM_W)) begin
          q_m <= sum_mag;
          r_m <= '0;
        end else begin
          r_m <= m_bit ? r_m_sh - {1'b0, cur.count} : r_m_sh;
          q_m <= {q_m[SUM_W-2:0], m_bit};
        end
        r_sq <= sq_bit ? r_sq_sh - {1'b0, cur.count} : r_sq_sh;
        q_sq <= {q_sq[SQ_W-2:0], sq_bit};
        step <= step + 1'b1;
        rres <= '0;
        rbit <= 32'h4000_0000;
      end
      wfs_pkg::ST_SQRT: begin
        if (step == CW'(SQ_W)) begin
          // last mean shift, then seed root operand
          r_m <= m_bit ? r_m_sh - {1'b0, cur.count} : r_m_sh;
          q_m <= {q_m[SUM_W-2:0], m_bit};
          rx <= q_sq;
          step <= step + 1'b1;
        end else if (rbit != '0) begin
          if ({{(SQ_W-34){1'b0}}, trial} <= rx) begin
            rx <= rx - SQ_W'(trial);
            rres <= (rres >> 1) + rbit;
          end else begin
            rres <= rres >> 1;
          end
          rbit <= rbit >> 2;
        end
      end
      wfs_pkg::ST_DONE: begin
        peak_value <= cur.bad ? '0 : cur.peak;
        peak_pos <= cur.bad ? '0 : cur.peak_pos;
        sample_min <= cur.bad ? '0 : cur.min_v;
        sample_max <= cur.bad ? '0 : cur.max_v;
        mean_value <= cur.bad ? '0 : (neg ? 16'(-q_m) : q_m[15:0]);
        rms_value <= cur.bad ? '0 : rres[15:0];
        frame_length <= cur.len;
        used_start <= cur.ustart;
        used_end <= cur.uend;
        quality_bad <= cur.bad;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> !res_valid) else $error("request taken while result waits");
  a_done_sets: assert property (@(posedge clk) disable iff (rst)
    state == wfs_pkg::ST_DONE |=> res_valid) else $error("result lost");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == wfs_pkg::ST_DIV |-> step < CW'(SQ_W)) else $error("divide overran");
`endif

endmodule
`default_nettype wire

[rtl/waveform_frame_statistics_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_frame_statistics_unit
// Per-frame peak, min, max, mean and rms of a Q1.15 sample stream.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle whenever full is low; the accumulators keep
// pace with the stream. At a due frame end, with features on, a summary
// enters a four-entry queue, and the math unit turns it into a result: it
// takes the summary, runs the shared shift-subtract divide, a seed step, 16
// root steps and an exit step, and loads the result register. The next
// summary starts only after the waiting result is popped. full rises when the
// queue holds three summaries, leaving room for one still in flight from the
// front, so frames shorter than the math time, or a receiver that holds off
// pop, back up the input.
module waveform_frame_statistics_unit (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire logic signed [15:0] sample,
  input wire logic sample_ok,
  input wire logic frame_end,
  output logic empty,
  input wire logic pop,
  output logic signed [15:0] peak_value,
  output logic [15:0] peak_pos,
  output logic signed [15:0] sample_min,
  output logic signed [15:0] sample_max,
  output logic signed [15:0] mean_value,
  output logic [15:0] rms_value,
  output logic [16:0] frame_length,
  output logic [16:0] used_start,
  output logic [16:0] used_end,
  output logic quality_bad,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [16:0] cfg_data
);

  logic [15:0] window_start;
  logic [16:0] window_end;
  logic [7:0] frame_stride;
  logic features_on;
  logic take, req_valid, q_has, q_afull, q_pop, res_valid;
  wfs_pkg::frame_req_t req, q_data;

  assign take = push && !full;
  // leave room for a request still in flight from the front
  assign full = q_afull;
  assign empty = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end <= '0;
      frame_stride <= 8'd1;
      features_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wfs_pkg::REG_WIN_START: window_start <= cfg_data[15:0];
        wfs_pkg::REG_WIN_END: window_end <= cfg_data;
        wfs_pkg::REG_STRIDE: frame_stride <= cfg_data[7:0];
        wfs_pkg::REG_FEATURES: features_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wfs_front u_front (
    .clk, .rst, .take, .sample, .sample_ok, .frame_end,
    .window_start, .window_end, .frame_stride, .features_on,
    .req_valid, .req
  );

  wfs_queue #(.DEPTH_LOG(2)) u_queue (
    .clk, .rst, .wr(req_valid), .wdata(req), .rd(q_pop),
    .has_data(q_has), .almost_full(q_afull), .rdata(q_data)
  );

  wfs_math u_math (
    .clk, .rst, .has_req(q_has), .req(q_data), .req_pop(q_pop),
    .res_valid, .res_pop(pop && res_valid),
    .peak_value, .peak_pos, .sample_min, .sample_max, .mean_value, .rms_value,
    .frame_length, .used_start, .used_end, .quality_bad
  );

`ifndef SYNTH
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !take) else $error("item taken while full");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty) else $error("result dropped");
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    !empty && pop |=> empty) else $error("result repeated");
`endif

endmodule
`default_nettype wire

[tb/sv/wfs_stats_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfs_stats_checker
// Watches the sample, result and register channels of the frame statistics
// unit, predicts each frame summary and compares it field by field.
// ----------------------------------------------------------------------------
module wfs_stats_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic signed [15:0] sample,
  input wire logic sample_ok,
  input wire logic frame_end,
  input wire logic empty,
  input wire logic pop,
  input wire logic signed [15:0] peak_value,
  input wire logic [15:0] peak_pos,
  input wire logic signed [15:0] sample_min,
  input wire logic signed [15:0] sample_max,
  input wire logic signed [15:0] mean_value,
  input wire logic [15:0] rms_value,
  input wire logic [16:0] frame_length,
  input wire logic [16:0] used_start,
  input wire logic [16:0] used_end,
  input wire logic quality_bad,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [16:0] cfg_data,
  output int errors,
  output int pending
);

  localparam int FRAME_CAP = 65536;

  typedef struct {
    logic signed [15:0] peak;
    logic [15:0] pos;
    logic signed [15:0] min_v;
    logic signed [15:0] max_v;
    logic signed [15:0] mean;
    logic [15:0] rms;
    logic [16:0] len;
    logic [16:0] ustart;
    logic [16:0] uend;
    logic bad;
  } frame_stats_t;

  frame_stats_t stats_q[$];

  logic [15:0] win_start;
  logic [16:0] win_end;
  logic [7:0] stride;
  logic feat_on;

  logic [16:0] idx;
  logic [16:0] vcount;
  logic signed [32:0] acc_sum;
  logic [46:0] acc_sq;
  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic signed [15:0] best;
  logic [15:0] best_pos;
  logic found;
  logic [7:0] phase;

  assign pending = stats_q.size();

  function automatic logic [23:0] floor_sqrt(logic [46:0] x);
    logic [23:0] r;
    logic [23:0] t;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (24'd1 << b);
      if (48'(t) * 48'(t) <= 48'(x)) r = t;
    end
    return r;
  endfunction

  task automatic clear_frame();
    idx = '0;
    vcount = '0;
    acc_sum = '0;
    acc_sq = '0;
    lo = 16'sh7fff;
    hi = 16'sh8000;
    best = 16'sh8000;
    best_pos = '0;
    found = 1'b0;
  endtask

  task automatic absorb_sample(logic signed [15:0] s, logic ok, logic fe);
    logic [15:0] mag;
    logic [16:0] len;
    logic due;
    longint m;
    longint q;
    frame_stats_t r;
    if (ok) begin
      mag = s[15] ? (~s + 16'd1) : s;
      vcount = vcount + 17'd1;
      acc_sum = acc_sum + s;
      acc_sq = acc_sq + 47'(mag) * 47'(mag);
      if (s < lo) lo = s;
      if (s > hi) hi = s;
      if (idx >= 17'(win_start) && (win_end == 0 || idx < win_end) &&
          (!found || s > best)) begin
        found = 1'b1;
        best = s;
        best_pos = idx[15:0];
      end
    end
    len = idx + 17'd1;
    if (!fe && int'(len) < FRAME_CAP) begin
      idx = len;
      return;
    end
    if (stride <= 8'd1) begin
      phase = '0;
      due = 1'b1;
    end else begin
      phase = phase + 8'd1;
      due = phase >= stride;
      if (due) phase = '0;
    end
    if (due && feat_on) begin
      r = '{default: '0};
      r.len = len;
      r.ustart = (17'(win_start) < len) ? 17'(win_start) : len;
      r.uend = (win_end == 0 || win_end > len) ? len : win_end;
      r.bad = (vcount == 0) || (r.ustart >= r.uend) || !found;
      if (!r.bad) begin
        m = acc_sum;
        q = (m < 0 ? -m : m) / longint'(vcount);
        r.peak = best;
        r.pos = best_pos;
        r.min_v = lo;
        r.max_v = hi;
        r.mean = 16'(m < 0 ? -q : q);
        r.rms = 16'(floor_sqrt(acc_sq / 47'(vcount)));
      end
      stats_q.push_back(r);
    end
    clear_frame();
  endtask

  task automatic report_mismatch(string field, logic [16:0] got, logic [16:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic check_field(string field, logic [16:0] got, logic [16:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  always @(posedge clk) begin
    frame_stats_t w;
    if (rst) begin
      win_start = '0;
      win_end = '0;
      stride = 8'd1;
      feat_on = 1'b1;
      phase = '0;
      clear_frame();
      stats_q.delete();
      errors = 0;
    end else begin
      // a sample at this edge still sees the old register values
      if (push && !full) absorb_sample(sample, sample_ok, frame_end);
      if (cfg_we) begin
        case (cfg_index)
          wfs_pkg::REG_WIN_START: win_start = cfg_data[15:0];
          wfs_pkg::REG_WIN_END: win_end = cfg_data;
          wfs_pkg::REG_STRIDE: stride = cfg_data[7:0];
          wfs_pkg::REG_FEATURES: feat_on = cfg_data[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (stats_q.size() == 0) begin
          report_mismatch("unexpected result", frame_length, '0);
        end else begin
          w = stats_q.pop_front();
          check_field("peak_value", 17'(peak_value[15:0]), 17'(w.peak[15:0]));
          check_field("peak_pos", 17'(peak_pos), 17'(w.pos));
          check_field("sample_min", 17'(sample_min[15:0]), 17'(w.min_v[15:0]));
          check_field("sample_max", 17'(sample_max[15:0]), 17'(w.max_v[15:0]));
          check_field("mean_value", 17'(mean_value[15:0]), 17'(w.mean[15:0]));
          check_field("rms_value", 17'(rms_value), 17'(w.rms));
          check_field("frame_length", frame_length, w.len);
          check_field("used_start", used_start, w.ustart);
          check_field("used_end", used_end, w.uend);
          check_field("quality_bad", 17'(quality_bad), 17'(w.bad));
        end
      end
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the waveform frame statistics unit: directed frames for the
// window and stride cases, then random frames under varied idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic signed [15:0] sample = '0;
  logic sample_ok = 1'b0;
  logic frame_end = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  logic full;
  logic empty;
  logic signed [15:0] peak_value;
  logic [15:0] peak_pos;
  logic signed [15:0] sample_min;
  logic signed [15:0] sample_max;
  logic signed [15:0] mean_value;
  logic [15:0] rms_value;
  logic [16:0] frame_length;
  logic [16:0] used_start;
  logic [16:0] used_end;
  logic quality_bad;

  int errors;
  int pending;
  int tx_idle = 0;
  int rx_idle = 0;
  bit rx_hold = 1'b0;
  int item_count;

  waveform_frame_statistics_unit dut (.*);

  wfs_stats_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Receiver: random pop, or a long counted hold-off when asked.
  initial begin
    forever begin
      if (rx_hold) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle);
        @(posedge clk);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_we || rst) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(logic signed [15:0] s, logic ok, logic fe);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    sample_ok <= ok;
    frame_end <= fe;
    @(posedge clk);
    while (full) @(posedge clk);
    item_count++;
  endtask

  // Hold the input until every expected result is out and the math is quiet.
  task automatic quiesce();
    push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(logic [16:0] ws, logic [16:0] we, logic [16:0] st,
                              logic [16:0] fo);
    cfg_we <= 1'b1;
    cfg_index <= wfs_pkg::REG_WIN_START;
    cfg_data <= ws;
    @(posedge clk);
    cfg_index <= wfs_pkg::REG_WIN_END;
    cfg_data <= we;
    @(posedge clk);
    cfg_index <= wfs_pkg::REG_STRIDE;
    cfg_data <= st;
    @(posedge clk);
    cfg_index <= wfs_pkg::REG_FEATURES;
    cfg_data <= fo;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(7)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [16:0] ws;
    logic [16:0] we;
    ws = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(8));
    case ($urandom_range(3))
      0: we = '0;
      1: we = 17'($urandom_range(20));
      default: we = ws[15:0] + 17'($urandom_range(1, 24));
    endcase
    quiesce();
    apply_config(ws, we, 17'($urandom_range(1, 3)),
                 17'($urandom_range(9) != 0) | (17'($urandom) & 17'h1fffe));
  endtask

  task automatic random_frame();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    for (int k = 0; k < len; k++) begin
      send(pick_sample(), $urandom_range(99) < 85, k == len - 1);
    end
  endtask

  initial begin
    @(negedge rst);
    @(posedge clk);

    // Reset settings: full frame window, every frame due.
    send(16'sh7fff, 1'b1, 1'b1);
    send(16'sh8000, 1'b1, 1'b0);
    send(16'sh7fff, 1'b1, 1'b0);
    send(16'sh0000, 1'b0, 1'b1);
    send(16'sh1234, 1'b0, 1'b0);
    send(16'sh1234, 1'b0, 1'b1);
    send(16'sh0005, 1'b1, 1'b0);
    send(16'sh0005, 1'b1, 1'b1);

    // Narrow window; upper bits of the start register are dropped.
    quiesce();
    apply_config(17'h10002, 17'd4, 17'd1, 17'd1);
    send(16'sh7000, 1'b1, 1'b0);
    send(16'sh0010, 1'b1, 1'b0);
    send(16'sh0020, 1'b0, 1'b0);
    send(16'sh0030, 1'b1, 1'b0);
    send(16'sh7fff, 1'b1, 1'b0);
    send(16'shffff, 1'b1, 1'b1);
    send(16'sh0100, 1'b1, 1'b1);

    // Extreme registers, features off: phase advances silently.
    quiesce();
    apply_config(17'h0ffff, 17'h10000, 17'h1ffff, 17'h1fffe);
    send(16'sh4000, 1'b1, 1'b1);
    send(16'shc000, 1'b1, 1'b1);

    // Raise the stride, then lower it.
    quiesce();
    apply_config(17'd0, 17'd0, 17'd4, 17'd1);
    send(16'sh0001, 1'b1, 1'b1);
    send(16'sh0002, 1'b1, 1'b1);
    quiesce();
    apply_config(17'd0, 17'd0, 17'd2, 17'd1);
    send(16'sh0003, 1'b1, 1'b1);
    send(16'sh0004, 1'b1, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 21 : (ph == 1) ? 64 : 0;
      rx_idle = (ph == 0) ? 64 : (ph == 1) ? 21 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        random_config();
        item_count = 0;
        while (item_count < 170) begin
          if (ph == 0 && blk == 1 && item_count > 60 && item_count < 80 && !rx_hold)
            rx_hold = 1'b1;
          if (ph == 1 && blk == 1 && item_count > 80 && item_count < 90) begin
            push <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
          end
          random_frame();
        end
      end
    end

    push <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
